>>> hw/rtl/obstacle_avoidance_fsm_macros.svh
// Assertion macros for the obstacle avoidance controller.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef OBSTACLE_AVOIDANCE_FSM_MACROS_SVH
`define OBSTACLE_AVOIDANCE_FSM_MACROS_SVH

// Same-cycle implication, disabled during reset
`define OAF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define OAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/oafsm_pkg.sv
// Shared types and constants for the obstacle avoidance controller.
// No dependencies.
package oafsm_pkg;

    // Controller modes; the value doubles as the result field mode_now
    typedef enum logic [2:0] {
        MODE_STRAIGHT = 3'd0,
        MODE_AVOID_L  = 3'd1,
        MODE_AVOID_R  = 3'd2,
        MODE_FOLLOW_L = 3'd3,
        MODE_FOLLOW_R = 3'd4,
        MODE_WAIT     = 3'd5
    } mode_t;

    // Drive commands
    typedef enum logic [1:0] {
        MOVE_FWD  = 2'd0,
        MOVE_RT   = 2'd1,
        MOVE_LF   = 2'd2,
        MOVE_STOP = 2'd3
    } move_t;

    // Remembered avoidance side; codes match the avoid modes
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_IR_TOL     = 3'd0;
    localparam logic [2:0] REG_IR_MIN     = 3'd1;
    localparam logic [2:0] REG_IR_MAX     = 3'd2;
    localparam logic [2:0] REG_US_FLOOR   = 3'd3;
    localparam logic [2:0] REG_US_MIN     = 3'd4;
    localparam logic [2:0] REG_WAIT_TICKS = 3'd5;

    // Register reset values
    localparam logic [9:0]  IR_TOL_RST     = 10'd20;
    localparam logic [9:0]  IR_MIN_RST     = 10'd200;
    localparam logic [9:0]  IR_MAX_RST     = 10'd600;
    localparam logic [15:0] US_FLOOR_RST   = 16'd10;
    localparam logic [15:0] US_MIN_RST     = 16'd300;
    localparam logic [12:0] WAIT_TICKS_RST = 13'd10;

    // Follow time as a multiple of the wait time, and the width of the product
    localparam int unsigned FOLLOW_FACTOR = 13;
    localparam int unsigned LIMIT_BITS    = 17;

endpackage

>>> hw/rtl/obstacle_avoidance_fsm.sv
// Obstacle avoidance controller: sensor stream in, drive command stream out.
// Depends on oafsm_pkg and obstacle_avoidance_fsm_macros.svh.
//
//  Channel   Dir  Beat contents
//  s_*       in   ir_left, ir_right, us_forward (one sensor tick)
//  m_*       out  movement, mode_now (one command per tick)
//  APB       in   six threshold/timing registers at 0x00..0x14
//
// One tick per cycle while m_tready keeps the result moving; a tick passes from the
// input register into the result register, from which its command leaves.
// The mode, side and counter update as a tick moves into the result register.
// m_tready low holds the result; the input register still takes one more tick,
// after which s_tready follows m_tready.
// Reset returns to straight, clears side and counter, loads register defaults.
`include "obstacle_avoidance_fsm_macros.svh"

module obstacle_avoidance_fsm
    import oafsm_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Sensor beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [9:0] ir_left, [19:10] ir_right, [35:20] us_forward
    // Command beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] movement, [4:2] mode_now
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    // Configuration registers
    logic [9:0]  ir_tol_reg, ir_min_reg, ir_max_reg;
    logic [15:0] us_floor_reg, us_min_reg;
    logic [12:0] wait_ticks_reg;
    logic        cfg_write;
    logic [2:0]  cfg_index;

    // Pipeline registers
    logic        in_valid_reg, in_valid_next;
    logic [9:0]  ir_left_reg, ir_right_reg;
    logic [15:0] us_fwd_reg;
    logic        out_valid_reg, out_valid_next;
    move_t       movement_reg;
    mode_t       mode_out_reg;
    logic        s_accept, advance;

    // Controller state
    mode_t                  mode_reg, mode_next;
    logic [1:0]             side_reg, side_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    move_t                  move;

    // Step terms
    logic [10:0]            ir_diff;
    logic                   unequal, ahead;
    logic [COUNT_BITS-1:0]  bump_val;
    logic [CMP_BITS-1:0]    follow_lim;
    logic                   follow_hit, wait_hit;

    // Check terms
    logic                   mode_agrees, follow_exit, avoid_step;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_tol_reg     <= IR_TOL_RST;
            ir_min_reg     <= IR_MIN_RST;
            ir_max_reg     <= IR_MAX_RST;
            us_floor_reg   <= US_FLOOR_RST;
            us_min_reg     <= US_MIN_RST;
            wait_ticks_reg <= WAIT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IR_TOL:     ir_tol_reg     <= pwdata[9:0];
                REG_IR_MIN:     ir_min_reg     <= pwdata[9:0];
                REG_IR_MAX:     ir_max_reg     <= pwdata[9:0];
                REG_US_FLOOR:   us_floor_reg   <= pwdata[15:0];
                REG_US_MIN:     us_min_reg     <= pwdata[15:0];
                REG_WAIT_TICKS: wait_ticks_reg <= pwdata[12:0];
                default:        ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (cfg_index)
            REG_IR_TOL:     prdata = {22'd0, ir_tol_reg};
            REG_IR_MIN:     prdata = {22'd0, ir_min_reg};
            REG_IR_MAX:     prdata = {22'd0, ir_max_reg};
            REG_US_FLOOR:   prdata = {16'd0, us_floor_reg};
            REG_US_MIN:     prdata = {16'd0, us_min_reg};
            REG_WAIT_TICKS: prdata = {19'd0, wait_ticks_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Hold control bits and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_STRAIGHT;
            side_reg      <= SIDE_NONE;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg  <= mode_next;
                side_reg  <= side_next;
                count_reg <= count_next;
            end
        end
    end

    // Capture the sensor beat
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ir_left_reg  <= s_tdata[9:0];
            ir_right_reg <= s_tdata[19:10];
            us_fwd_reg   <= s_tdata[35:20];
        end
    end

    // Capture the command beat
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            movement_reg <= move;
            mode_out_reg <= mode_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, mode_out_reg, movement_reg};

    // ---------------------------------------------------------------- step terms
    assign ir_diff = (ir_left_reg >= ir_right_reg)
                   ? ({1'b0, ir_left_reg} - {1'b0, ir_right_reg})
                   : ({1'b0, ir_right_reg} - {1'b0, ir_left_reg});
    assign unequal = ir_diff > {1'b0, ir_tol_reg};
    assign ahead   = (us_fwd_reg < us_min_reg) && (us_fwd_reg > us_floor_reg);

    // Saturating tick count and its two timing compares
    assign bump_val   = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg
                                                          : count_reg + COUNT_BITS'(1);
    assign follow_lim = CMP_BITS'(wait_ticks_reg) * CMP_BITS'(FOLLOW_FACTOR);
    assign follow_hit = CMP_BITS'(bump_val) >= follow_lim;
    assign wait_hit   = CMP_BITS'(bump_val) >= CMP_BITS'(wait_ticks_reg);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        mode_next  = mode_reg;
        side_next  = side_reg;
        count_next = count_reg;
        move       = MOVE_STOP;
        case (mode_reg)
            MODE_STRAIGHT:
            begin
                move = MOVE_FWD;
                // Obstacle ahead with balanced sides: turn away on the remembered side, right if none
                if (!unequal && ahead)
                begin
                    if (side_reg == SIDE_NONE)
                        side_next = SIDE_RIGHT;
                    mode_next  = mode_t'({1'b0, side_next});
                    count_next = '0;
                end
                // Long enough beside a wall on the remembered side: follow it
                if (mode_next == MODE_STRAIGHT && side_next == SIDE_LEFT &&
                    ir_left_reg >= ir_max_reg)
                begin
                    count_next = bump_val;
                    if (follow_hit)
                    begin
                        mode_next  = MODE_FOLLOW_L;
                        count_next = '0;
                    end
                end
                else if (mode_next == MODE_STRAIGHT && side_next == SIDE_RIGHT &&
                         ir_right_reg >= ir_max_reg)
                begin
                    count_next = bump_val;
                    if (follow_hit)
                    begin
                        mode_next  = MODE_FOLLOW_R;
                        count_next = '0;
                    end
                end
                // Unequal sides: turn away from a near side
                else if (unequal)
                begin
                    count_next = '0;
                    if (ir_left_reg < ir_right_reg && (ir_left_reg < ir_min_reg || ahead))
                        mode_next = MODE_AVOID_L;
                    else if (ir_left_reg > ir_right_reg &&
                             (ir_right_reg < ir_min_reg || ahead))
                        mode_next = MODE_AVOID_R;
                end
            end
            MODE_AVOID_L:
            begin
                move      = MOVE_RT;
                side_next = SIDE_LEFT;
                if (ir_left_reg >= ir_min_reg && us_fwd_reg >= us_min_reg)
                    mode_next = MODE_WAIT;
            end
            MODE_AVOID_R:
            begin
                move      = MOVE_LF;
                side_next = SIDE_RIGHT;
                if (ir_right_reg >= ir_min_reg && us_fwd_reg >= us_min_reg)
                    mode_next = MODE_WAIT;
            end
            MODE_FOLLOW_L:
            begin
                move       = MOVE_LF;
                count_next = bump_val;
                if (follow_hit)
                    side_next = SIDE_NONE;
                // Wall lost or follow time spent: stop and wait
                if (ir_left_reg <= ir_max_reg || side_next == SIDE_NONE)
                begin
                    count_next = '0;
                    mode_next  = MODE_WAIT;
                end
            end
            MODE_FOLLOW_R:
            begin
                move       = MOVE_RT;
                count_next = bump_val;
                if (follow_hit)
                    side_next = SIDE_NONE;
                if (ir_right_reg <= ir_max_reg || side_next == SIDE_NONE)
                begin
                    count_next = '0;
                    mode_next  = MODE_WAIT;
                end
            end
            default:
            begin
                // Wait, and any unused code: stop until the wait time is spent
                move       = MOVE_STOP;
                count_next = bump_val;
                if (wait_hit)
                begin
                    mode_next  = MODE_STRAIGHT;
                    count_next = '0;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------- checks
    assign mode_agrees = mode_out_reg == mode_reg;
    assign follow_exit = advance && (mode_reg == MODE_FOLLOW_L || mode_reg == MODE_FOLLOW_R)
                         && (mode_next == MODE_WAIT);
    assign avoid_step  = advance && (mode_reg == MODE_AVOID_L || mode_reg == MODE_AVOID_R);

    // The mode in a waiting result agrees with the controller state
    `OAF_ASSERT_IMPL(a_out_mode, out_valid_reg, mode_agrees, "result mode differs from state")
    // Leaving a follow mode for wait clears the counter
    `OAF_ASSERT_NEXT(a_follow_exit, follow_exit, count_reg == '0, "counter kept on follow exit")
    // Avoid modes leave the counter untouched
    `OAF_ASSERT_NEXT(a_avoid_count, avoid_step, $stable(count_reg), "counter moved in avoid")

endmodule

>>> tb/sv/obstacle_avoidance_fsm_tb.sv
// Self-checking testbench for the obstacle avoidance controller: sensor beats in,
// command beats checked against a cycle-free model of the mode machine kept here.
// Depends on oafsm_pkg and the obstacle_avoidance_fsm top level; reads no files.
module obstacle_avoidance_fsm_tb;
    import oafsm_pkg::*;

    localparam int COUNT_BITS      = 16;
    localparam int IR_TOP          = 1023;
    localparam int US_TOP          = 65535;
    localparam int WAIT_TOP        = 8191;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 7;
    localparam int PHASE_TICKS     = 220;
    localparam int CYCLE_LIMIT     = 400000;

    typedef struct packed {
        move_t movement;
        mode_t mode_now;
    } command_t;

    // Kinds of road the random part strings together
    typedef enum int {
        SCENE_OPEN,
        SCENE_AHEAD,
        SCENE_NEAR_LEFT,
        SCENE_NEAR_RIGHT,
        SCENE_WALL_LEFT,
        SCENE_WALL_RIGHT,
        SCENE_NOISE
    } scene_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [9:0] ir_left, [19:10] ir_right, [35:20] us_forward
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [1:0] movement, [4:2] mode_now
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register copy and controller state as seen by the model
    logic [9:0]            cfg_ir_tol     = IR_TOL_RST;
    logic [9:0]            cfg_ir_min     = IR_MIN_RST;
    logic [9:0]            cfg_ir_max     = IR_MAX_RST;
    logic [15:0]           cfg_us_floor   = US_FLOOR_RST;
    logic [15:0]           cfg_us_min     = US_MIN_RST;
    logic [12:0]           cfg_wait_ticks = WAIT_TICKS_RST;
    mode_t                 pred_mode      = MODE_STRAIGHT;
    logic [1:0]            pred_side      = SIDE_NONE;
    logic [COUNT_BITS-1:0] pred_ticks     = '0;

    command_t    commands_due[$];
    int          errors           = 0;
    int          ticks_sent       = 0;
    int          commands_checked = 0;
    int          reg_writes       = 0;
    int          mode_hits[6]     = '{default: 0};
    int          burst_left       = 0;
    bit          src_gaps         = 1'b1;
    bit          sink_stalls      = 1'b1;
    bit          hold_off_req     = 1'b0;
    int          hold_left        = 0;
    int          ready_left       = 0;
    int          stall_left       = 0;
    int unsigned cycle_count      = 0;

    obstacle_avoidance_fsm #(.COUNT_BITS(COUNT_BITS)) uut (.*);

    always #6 clk = ~clk;

    // Random value in [lo, hi], both clipped to [0, top]
    function automatic int span(int lo, int hi, int top);
        if (lo < 0) lo = 0;
        if (lo > top) lo = top;
        if (hi > top) hi = top;
        if (hi < lo) hi = lo;
        return $urandom_range(hi, lo);
    endfunction

    // Saturating tick counter; returns the new count
    function automatic logic [COUNT_BITS-1:0] tick_up();
        if (pred_ticks != '1)
            pred_ticks = pred_ticks + 1'b1;
        return pred_ticks;
    endfunction

    // Advance the mode machine by one sensor tick and return its command
    function automatic command_t next_command(logic [9:0] l, logic [9:0] r, logic [15:0] us);
        logic [LIMIT_BITS-1:0] follow_lim;
        logic                  ahead;
        logic                  unequal;
        int                    diff;
        command_t              cmd;
        follow_lim   = LIMIT_BITS'(cfg_wait_ticks * FOLLOW_FACTOR);
        ahead        = (us < cfg_us_min) && (us > cfg_us_floor);
        cmd.movement = MOVE_STOP;
        case (pred_mode)
            MODE_STRAIGHT:
            begin
                cmd.movement = MOVE_FWD;
                diff    = int'(l) - int'(r);
                unequal = (diff > int'(cfg_ir_tol)) || (-diff > int'(cfg_ir_tol));
                // Obstacle dead ahead: turn away on the remembered side, right by default
                if (!unequal && ahead)
                begin
                    if (pred_side == SIDE_NONE)
                        pred_side = SIDE_RIGHT;
                    pred_mode  = mode_t'({1'b0, pred_side});
                    pred_ticks = '0;
                end
                if (pred_mode == MODE_STRAIGHT && pred_side == SIDE_LEFT && l >= cfg_ir_max)
                begin
                    if (tick_up() >= follow_lim)
                    begin
                        pred_mode  = MODE_FOLLOW_L;
                        pred_ticks = '0;
                    end
                end
                else if (pred_mode == MODE_STRAIGHT && pred_side == SIDE_RIGHT &&
                         r >= cfg_ir_max)
                begin
                    if (tick_up() >= follow_lim)
                    begin
                        pred_mode  = MODE_FOLLOW_R;
                        pred_ticks = '0;
                    end
                end
                else if (unequal)
                begin
                    pred_ticks = '0;
                    if (l < r && (l < cfg_ir_min || ahead))
                        pred_mode = MODE_AVOID_L;
                    else if (l > r && (r < cfg_ir_min || ahead))
                        pred_mode = MODE_AVOID_R;
                end
            end
            MODE_AVOID_L:
            begin
                cmd.movement = MOVE_RT;
                pred_side    = SIDE_LEFT;
                if (l >= cfg_ir_min && us >= cfg_us_min)
                    pred_mode = MODE_WAIT;
            end
            MODE_AVOID_R:
            begin
                cmd.movement = MOVE_LF;
                pred_side    = SIDE_RIGHT;
                if (r >= cfg_ir_min && us >= cfg_us_min)
                    pred_mode = MODE_WAIT;
            end
            // Follow left ends in wait; it never drops into follow right
            MODE_FOLLOW_L:
            begin
                cmd.movement = MOVE_LF;
                if (tick_up() >= follow_lim)
                    pred_side = SIDE_NONE;
                if (l <= cfg_ir_max || pred_side == SIDE_NONE)
                begin
                    pred_ticks = '0;
                    pred_mode  = MODE_WAIT;
                end
            end
            MODE_FOLLOW_R:
            begin
                cmd.movement = MOVE_RT;
                if (tick_up() >= follow_lim)
                    pred_side = SIDE_NONE;
                if (r <= cfg_ir_max || pred_side == SIDE_NONE)
                begin
                    pred_ticks = '0;
                    pred_mode  = MODE_WAIT;
                end
            end
            default:
            begin
                cmd.movement = MOVE_STOP;
                if (tick_up() >= cfg_wait_ticks)
                begin
                    pred_mode  = MODE_STRAIGHT;
                    pred_ticks = '0;
                end
            end
        endcase
        cmd.mode_now = pred_mode;
        return cmd;
    endfunction

    function automatic logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            REG_IR_TOL:     return 32'(cfg_ir_tol);
            REG_IR_MIN:     return 32'(cfg_ir_min);
            REG_IR_MAX:     return 32'(cfg_ir_max);
            REG_US_FLOOR:   return 32'(cfg_us_floor);
            REG_US_MIN:     return 32'(cfg_us_min);
            REG_WAIT_TICKS: return 32'(cfg_wait_ticks);
            default:        return '0;
        endcase
    endfunction

    // One APB transfer: setup, access, then an idle pause with psel low
    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_IR_TOL:     cfg_ir_tol     = value[9:0];
            REG_IR_MIN:     cfg_ir_min     = value[9:0];
            REG_IR_MAX:     cfg_ir_max     = value[9:0];
            REG_US_FLOOR:   cfg_us_floor   = value[15:0];
            REG_US_MIN:     cfg_us_min     = value[15:0];
            REG_WAIT_TICKS: cfg_wait_ticks = value[12:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] got;
        apb_access(1'b0, idx, '0, got);
        if (got !== reg_value(idx))
        begin
            $error("register %0d: expected %0d, got %0d", idx, reg_value(idx), got);
            errors++;
        end
    endtask

    // Drop valid and hold until every command is back
    task automatic drain();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (commands_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_thresholds(input int ir_tol, input int ir_min, input int ir_max,
                                   input int us_floor, input int us_min, input int wait_ticks);
        drain();
        write_reg(REG_IR_TOL, ir_tol);
        write_reg(REG_IR_MIN, ir_min);
        write_reg(REG_IR_MAX, ir_max);
        write_reg(REG_US_FLOOR, us_floor);
        write_reg(REG_US_MIN, us_min);
        write_reg(REG_WAIT_TICKS, wait_ticks);
    endtask

    // Offer one sensor beat, with a random gap at the start of each burst when src_gaps is set
    task automatic send_tick(input logic [9:0] l, input logic [9:0] r, input logic [15:0] us);
        command_t cmd;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(3, 0) == 0) ? span(40, 120, 120) : span(1, 24, 24);
            if (src_gaps)
            begin
                s_tvalid <= 1'b0;
                repeat (span(1, 7, 7)) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, us, r, l};
        do
            @(posedge clk);
        while (!s_tready);
        cmd = next_command(l, r, us);
        commands_due.push_back(cmd);
        mode_hits[cmd.mode_now]++;
        ticks_sent++;
        burst_left--;
    endtask

    // Generate n sensor ticks of one kind of road, shaped by the current thresholds
    task automatic drive_scene(input scene_t scene, input int n);
        int base;
        int l;
        int r;
        int us;
        repeat (n)
        begin
            base = span(cfg_ir_min, IR_TOP, IR_TOP);
            l    = base;
            r    = span(base - cfg_ir_tol, base + cfg_ir_tol, IR_TOP);
            us   = span(cfg_us_min, US_TOP, US_TOP);
            case (scene)
                SCENE_AHEAD:
                    us = span(cfg_us_floor + 1, cfg_us_min - 1, US_TOP);
                SCENE_NEAR_LEFT:
                begin
                    l = span(0, cfg_ir_min - 1, IR_TOP);
                    r = span(l + cfg_ir_tol + 1, IR_TOP, IR_TOP);
                end
                SCENE_NEAR_RIGHT:
                begin
                    r = span(0, cfg_ir_min - 1, IR_TOP);
                    l = span(r + cfg_ir_tol + 1, IR_TOP, IR_TOP);
                end
                SCENE_WALL_LEFT:
                begin
                    l = span(cfg_ir_max + 1, IR_TOP, IR_TOP);
                    r = span(cfg_ir_min, cfg_ir_max, IR_TOP);
                end
                SCENE_WALL_RIGHT:
                begin
                    r = span(cfg_ir_max + 1, IR_TOP, IR_TOP);
                    l = span(cfg_ir_min, cfg_ir_max, IR_TOP);
                end
                SCENE_NOISE:
                begin
                    l  = $urandom_range(IR_TOP, 0);
                    r  = $urandom_range(IR_TOP, 0);
                    us = $urandom_range(US_TOP, 0);
                end
                default: ;
            endcase
            send_tick(l, r, us);
        end
    endtask

    // Reset values, then all-ones and all-zeros writes read back masked
    task automatic test_register_access();
        for (int i = REG_IR_TOL; i <= REG_WAIT_TICKS; i++)
            check_reg(3'(i));
        for (int i = REG_IR_TOL; i <= REG_WAIT_TICKS; i++)
        begin
            write_reg(3'(i), '1);
            check_reg(3'(i));
            write_reg(3'(i), '0);
            check_reg(3'(i));
        end
    endtask

    // Walk every mode and command by hand, with a zero wait time so timing fires at once
    task automatic test_directed_ticks();
        load_thresholds(IR_TOL_RST, IR_MIN_RST, IR_MAX_RST, US_FLOOR_RST, US_MIN_RST, 0);
        send_tick(10'd0, 10'd0, 16'd0);
        send_tick(10'd1023, 10'd1023, 16'd65535);
        send_tick(10'd100, 10'd400, 16'd5000);    // near left: avoid left
        send_tick(10'd100, 10'd400, 16'd100);
        send_tick(10'd300, 10'd300, 16'd500);     // clear: wait
        send_tick(10'd300, 10'd300, 16'd500);     // zero wait: straight at once
        send_tick(10'd700, 10'd300, 16'd5000);    // wall on the left: follow left
        send_tick(10'd700, 10'd300, 16'd5000);    // follow left ends in wait only
        send_tick(10'd300, 10'd300, 16'd500);
        send_tick(10'd400, 10'd100, 16'd5000);    // near right: avoid right
        send_tick(10'd400, 10'd100, 16'd5000);
        send_tick(10'd400, 10'd400, 16'd500);
        send_tick(10'd400, 10'd400, 16'd500);
        send_tick(10'd300, 10'd700, 16'd5000);    // wall on the right: follow right
        send_tick(10'd300, 10'd700, 16'd5000);
        send_tick(10'd300, 10'd300, 16'd500);
        send_tick(10'd500, 10'd500, 16'd100);     // obstacle ahead, sides equal
        send_tick(10'd500, 10'd500, 16'd11);
        send_tick(10'd500, 10'd500, 16'd300);     // forward distance exactly at the minimum
        send_tick(10'd500, 10'd500, 16'd300);
        send_tick(10'd500, 10'd510, 16'd10);      // forward reading at the noise floor
        send_tick(10'd500, 10'd521, 16'd200);     // just unequal with an obstacle ahead
    endtask

    // Cross the follow limit beside a left wall, then climb far under a distant limit
    task automatic test_follow_timing();
        load_thresholds(IR_TOL_RST, IR_MIN_RST, IR_MAX_RST, US_FLOOR_RST, US_MIN_RST, 3);
        repeat (6) send_tick(10'd300, 10'd300, 16'd500);
        send_tick(10'd100, 10'd400, 16'd5000);
        repeat (5) send_tick(10'd300, 10'd300, 16'd500);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        repeat (3 * FOLLOW_FACTOR + 4) send_tick(10'd700, 10'd300, 16'd5000);
        repeat (5) send_tick(10'd300, 10'd300, 16'd500);
        load_thresholds(IR_TOL_RST, IR_MIN_RST, IR_MAX_RST, US_FLOOR_RST, US_MIN_RST,
                        WAIT_TOP);
        repeat (100) send_tick(10'd700, 10'd300, 16'd5000);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // Starve the command side for a long stretch while sensor beats keep coming
    task automatic test_backpressure();
        load_thresholds(IR_TOL_RST, IR_MIN_RST, IR_MAX_RST, US_FLOOR_RST, US_MIN_RST, 2);
        src_gaps     = 1'b0;
        hold_off_req = 1'b1;
        drive_scene(SCENE_NOISE, 20);
        drive_scene(SCENE_AHEAD, 20);
        src_gaps = 1'b1;
    endtask

    // Phases of random roads under default, extreme and random thresholds
    task automatic test_random_phases();
        int     left;
        int     run;
        int     pick;
        scene_t scene;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: load_thresholds(IR_TOL_RST, IR_MIN_RST, IR_MAX_RST,
                                   US_FLOOR_RST, US_MIN_RST, WAIT_TICKS_RST);
                1: load_thresholds(0, 0, 0, 0, 0, 0);
                2: load_thresholds(IR_TOP, IR_TOP, IR_TOP, US_TOP, US_TOP, WAIT_TOP);
                default: load_thresholds(span(0, 60, IR_TOP), span(50, 500, IR_TOP),
                                         span(400, 1000, IR_TOP), span(0, 50, US_TOP),
                                         span(100, 2000, US_TOP),
                                         ($urandom_range(3, 0) == 0) ? span(7, 40, WAIT_TOP)
                                                                     : span(0, 6, WAIT_TOP));
            endcase
            src_gaps    = (p != 3);
            sink_stalls = (p != 4);
            left        = PHASE_TICKS;
            while (left > 0)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 30)      scene = SCENE_OPEN;
                else if (pick < 45) scene = SCENE_AHEAD;
                else if (pick < 53) scene = SCENE_NEAR_LEFT;
                else if (pick < 61) scene = SCENE_NEAR_RIGHT;
                else if (pick < 73) scene = SCENE_WALL_LEFT;
                else if (pick < 85) scene = SCENE_WALL_RIGHT;
                else                scene = SCENE_NOISE;
                // Wall runs are random, up to 20 ticks past the follow limit but no more than 200
                if (scene == SCENE_WALL_LEFT || scene == SCENE_WALL_RIGHT)
                    run = span(1, int'(cfg_wait_ticks) * FOLLOW_FACTOR + 20, 200);
                else
                    run = span(1, 12, 12);
                if (run > left)
                    run = left;
                drive_scene(scene, run);
                left -= run;
            end
        end
    endtask

    // Command side: ready runs and stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off_req)
        begin
            hold_off_req <= 1'b0;
            hold_left    <= HOLD_OFF_CYCLES;
            m_tready     <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (!sink_stalls || ready_left != 0)
        begin
            ready_left <= (ready_left != 0) ? ready_left - 1 : 0;
            m_tready   <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else
        begin
            ready_left <= $urandom_range(20, 1);
            stall_left <= $urandom_range(6, 1);
            m_tready   <= 1'b1;
        end
    end

    // Compare each command beat with the oldest expectation
    always @(posedge clk)
    begin : command_check
        command_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (commands_due.size() == 0)
            begin
                $error("command beat with nothing expected: movement %0d, mode_now %0d",
                       m_tdata[1:0], m_tdata[4:2]);
                errors++;
            end
            else
            begin
                want = commands_due.pop_front();
                if (m_tdata[1:0] !== want.movement)
                begin
                    $error("movement: expected %0d, got %0d", want.movement, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[4:2] !== want.mode_now)
                begin
                    $error("mode_now: expected %0d, got %0d", want.mode_now, m_tdata[4:2]);
                    errors++;
                end
                commands_checked++;
            end
        end
    end

    // Give up on a hung run
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d commands outstanding",
                 cycle_count, commands_due.size());
        $display("obstacle_avoidance_fsm_tb: errors");
        $finish;
    end

    initial
    begin : run_tests
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_ticks();
        test_follow_timing();
        test_backpressure();
        test_random_phases();

        drain();
        if (commands_due.size() != 0)
        begin
            $error("%0d expected commands never arrived", commands_due.size());
            errors++;
        end
        $display("%0d sensor ticks, %0d commands checked, %0d register writes",
                 ticks_sent, commands_checked, reg_writes);
        $display("ticks ending in straight %0d, avoid L %0d, avoid R %0d, follow L %0d, %s%0d, %s%0d",
                 mode_hits[MODE_STRAIGHT], mode_hits[MODE_AVOID_L], mode_hits[MODE_AVOID_R],
                 mode_hits[MODE_FOLLOW_L], "follow R ", mode_hits[MODE_FOLLOW_R],
                 "wait ", mode_hits[MODE_WAIT]);
        if (errors == 0)
            $display("obstacle_avoidance_fsm_tb: clean");
        else
            $display("obstacle_avoidance_fsm_tb: errors");
        $finish;
    end

endmodule
